// ===== sv/fspe_pkg.sv =====
// ----------------------------------------------------------------------------
// fspe_pkg
// Shared widths, constants, control types and the arctangent table of the
// Fourier series point evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fspe_pkg;

   // angle resolution and CORDIC length
   localparam int ANGLE_BITS   = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int TABLE_LEN    = 24;
   localparam int ITER_COUNT   = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   localparam int STEP_W       = 5;      // indexes the 24-entry table

   // payload widths
   localparam int HARM_W  = 11;
   localparam int AMP_W   = 20;
   localparam int PHASE_W = 16;
   localparam int TIME_W  = 17;
   localparam int POINT_W = 22;

   // datapath widths
   localparam int GAIN_W     = 30;
   localparam int GPROD_W    = AMP_W + GAIN_W;     // amplitude * gain
   localparam int GAIN_SHIFT = 16;
   localparam int X0_W       = GPROD_W - GAIN_SHIFT;
   localparam int HPROD_W    = HARM_W + TIME_W + 1;
   localparam int TURN_W     = 32;
   localparam int ANG_W      = TURN_W + 1;         // signed residual angle
   localparam int VEC_W      = 37;                 // CORDIC x / y
   localparam int EXTRA_BITS = 14;
   localparam int CPT_W      = VEC_W - EXTRA_BITS; // rounded component
   localparam int ACC_W      = POINT_W + 2;

   localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;

   localparam logic [TURN_W-1:0] ANGLE_MASK = 32'hFFFF_FFFF << (TURN_W - ANGLE_BITS);

   localparam logic signed [ANG_W-1:0] QUARTER_TURN = 33'sh0_4000_0000;
   localparam logic signed [ANG_W-1:0] HALF_TURN    = 33'sh0_8000_0000;

   localparam logic signed [VEC_W-1:0] RND_BIAS = VEC_W'(1 << (EXTRA_BITS - 1));

   localparam logic [TIME_W-1:0] FULL_TURN = 17'h1_0000;

   localparam logic signed [POINT_W-1:0] POINT_MAX = 22'sh1F_FFFF;
   localparam logic signed [POINT_W-1:0] POINT_MIN = 22'sh20_0000;

   // commands from the controller to the datapath
   typedef struct packed {
      logic              load;   // capture a term
      logic              mul;    // angle and gain products
      logic              prep;   // quarter-turn reduction, seed vector
      logic              iter;   // one CORDIC micro-rotation
      logic              rnd;    // undo flip, round to 8 fraction bits
      logic              acc;    // add to sums, emit on last term
      logic [STEP_W-1:0] step;   // micro-rotation index
   } fspe_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic last;       // captured term ends a frame
      logic out_busy;   // result register holds a point not yet taken
   } fspe_status_type;

   // arctangent of 2^-i in 2^-32 turn
   function automatic logic [TURN_W-1:0] atan_turns(input logic [STEP_W-1:0] idx);
      logic [TURN_W-1:0] val;
      case (idx)
         5'd0:    val = 32'h2000_0000;
         5'd1:    val = 32'h12E4_051E;
         5'd2:    val = 32'h09FB_385B;
         5'd3:    val = 32'h0511_11D4;
         5'd4:    val = 32'h028B_0D43;
         5'd5:    val = 32'h0145_D7E1;
         5'd6:    val = 32'h00A2_F61E;
         5'd7:    val = 32'h0051_7C55;
         5'd8:    val = 32'h0028_BE53;
         5'd9:    val = 32'h0014_5F2F;
         5'd10:   val = 32'h000A_2F98;
         5'd11:   val = 32'h0005_17CC;
         5'd12:   val = 32'h0002_8BE6;
         5'd13:   val = 32'h0001_45F3;
         5'd14:   val = 32'h0000_A2FA;
         5'd15:   val = 32'h0000_517D;
         5'd16:   val = 32'h0000_28BE;
         5'd17:   val = 32'h0000_145F;
         5'd18:   val = 32'h0000_0A30;
         5'd19:   val = 32'h0000_0518;
         5'd20:   val = 32'h0000_028C;
         5'd21:   val = 32'h0000_0146;
         5'd22:   val = 32'h0000_00A3;
         5'd23:   val = 32'h0000_0051;
         default: val = 32'h0000_0000;
      endcase
      return val;
   endfunction

endpackage

// ===== sv/fourier_series_point_eval_core.sv =====
// ----------------------------------------------------------------------------
// fourier_series_point_eval_core
// Each transfer on req_ is one Fourier term; once taken it occupies the
// block for the angle and radius products, the quarter-turn reduction,
// 16 iterations of the single shared CORDIC shift-add unit, rounding and
// accumulation, and the next term is not taken until it leaves
// accumulation. A term marked last_term also moves the point into the
// result register; if a previous point is still stalled there, that term
// waits in accumulation until it leaves. A new term is taken while a point
// waits on rsp_. Write time_step on csr_ only while no term is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fourier_series_point_eval_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [fspe_pkg::HARM_W-1:0]   req_harmonic,
   input  logic [fspe_pkg::AMP_W-1:0]          req_amplitude,
   input  logic [fspe_pkg::PHASE_W-1:0]        req_phase_turns,
   input  logic                                req_last_term,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [fspe_pkg::POINT_W-1:0]  rsp_point_x,
   output logic signed [fspe_pkg::POINT_W-1:0]  rsp_point_y,
   output logic                                rsp_period_wrapped,
   input  logic                                csr_wr_en,
   input  logic [fspe_pkg::TIME_W-1:0]         csr_wr_data
);
   import fspe_pkg::*;

   fspe_cmd_type    cmd;
   fspe_status_type status;

   // sequencer
   fspe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and storage
   fspe_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_harmonic       (req_harmonic),
      .req_amplitude      (req_amplitude),
      .req_phase_turns    (req_phase_turns),
      .req_last_term      (req_last_term),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_point_x        (rsp_point_x),
      .rsp_point_y        (rsp_point_y),
      .rsp_period_wrapped (rsp_period_wrapped),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

endmodule

// ===== sv/fspe_ctrl.sv =====
// ----------------------------------------------------------------------------
// fspe_ctrl
// Sequencer of the point evaluator: takes a term, steps the datapath through
// products, reduction, CORDIC iterations, rounding and accumulation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fspe_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  fspe_pkg::fspe_status_type status,
   output fspe_pkg::fspe_cmd_type    cmd
);
   import fspe_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_MUL  = 6'b000010,
      S_PREP = 6'b000100,
      S_ITER = 6'b001000,
      S_RND  = 6'b010000,
      S_ACC  = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              acc_go;

   // a last term waits here until the result register is free
   assign acc_go = !(status.last && status.out_busy);

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_PREP;
         end
         S_PREP: begin
            state_in = S_ITER;
            step_in  = '0;
         end
         S_ITER: begin
            if (step_ff == STEP_W'(ITER_COUNT - 1)) begin
               state_in = S_RND;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_RND: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            if (acc_go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // commands
   assign req_stall = (state_ff != S_IDLE);
   assign cmd.load  = (state_ff == S_IDLE) && req_valid;
   assign cmd.mul   = (state_ff == S_MUL);
   assign cmd.prep  = (state_ff == S_PREP);
   assign cmd.iter  = (state_ff == S_ITER);
   assign cmd.rnd   = (state_ff == S_RND);
   assign cmd.acc   = (state_ff == S_ACC) && acc_go;
   assign cmd.step  = step_ff;

`ifndef SYNTHESIS
   // the iteration index never runs past the table
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_W'(ITER_COUNT - 1))
      else $error("CORDIC step index out of range");

   // a full CORDIC run always precedes rounding
   a_iter_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RND) |-> $past(state_ff == S_ITER)
                              && $past(step_ff == STEP_W'(ITER_COUNT - 1)))
      else $error("rounding entered before CORDIC finished");

   // a term accepted goes straight to the product stage
   a_load_next: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == S_MUL))
      else $error("accepted term not processed");
`endif

endmodule

// ===== sv/fspe_datapath.sv =====
// ----------------------------------------------------------------------------
// fspe_datapath
// Term registers, angle and gain multipliers, shared CORDIC shift-add unit,
// rounding, saturating sums, time position and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fspe_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fspe_pkg::fspe_cmd_type                cmd,
   output fspe_pkg::fspe_status_type             status,
   input  logic signed [fspe_pkg::HARM_W-1:0]    req_harmonic,
   input  logic [fspe_pkg::AMP_W-1:0]           req_amplitude,
   input  logic [fspe_pkg::PHASE_W-1:0]         req_phase_turns,
   input  logic                                 req_last_term,
   input  logic                                 req_restart,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [fspe_pkg::POINT_W-1:0]   rsp_point_x,
   output logic signed [fspe_pkg::POINT_W-1:0]   rsp_point_y,
   output logic                                 rsp_period_wrapped,
   input  logic                                 csr_wr_en,
   input  logic [fspe_pkg::TIME_W-1:0]          csr_wr_data
);
   import fspe_pkg::*;

   // saturate a widened sum to the point range
   function automatic logic signed [POINT_W-1:0] sat_point(input logic signed [ACC_W-1:0] v);
      logic signed [POINT_W-1:0] r;
      if (v > ACC_W'(POINT_MAX)) begin
         r = POINT_MAX;
      end else if (v < ACC_W'(POINT_MIN)) begin
         r = POINT_MIN;
      end else begin
         r = v[POINT_W-1:0];
      end
      return r;
   endfunction

   // configuration and state
   logic [TIME_W-1:0]         time_step_ff;
   logic [TIME_W-1:0]         tp_ff;
   logic signed [POINT_W-1:0] sum_x_ff, sum_y_ff;

   // captured term
   logic signed [HARM_W-1:0]  harm_ff;
   logic [AMP_W-1:0]          amp_ff;
   logic [PHASE_W-1:0]        phase_ff;
   logic                      last_ff;

   // product stage
   logic [PHASE_W-1:0]        a16_ff;
   logic [X0_W-1:0]           x0_ff;
   logic signed [HPROD_W-1:0] hprod;
   logic [GPROD_W-1:0]        gprod;
   logic [PHASE_W-1:0]        a16_in;

   // reduction and CORDIC
   logic [TURN_W-1:0]         turn;
   logic signed [ANG_W-1:0]   z_raw;
   logic signed [ANG_W-1:0]   z_ff;
   logic signed [VEC_W-1:0]   x_ff, y_ff;
   logic                      flip_ff;
   logic signed [VEC_W-1:0]   xs, ys;
   logic signed [ANG_W-1:0]   at;

   // rounding and accumulation
   logic signed [VEC_W-1:0]   rx, ry;
   logic signed [CPT_W-1:0]   cx_ff, sy_ff;
   logic signed [ACC_W-1:0]   ax, ay;
   logic signed [POINT_W-1:0] sum_x_in, sum_y_in;
   logic [TIME_W:0]           t_next;
   logic                      wrap;

   // result register
   logic                      rsp_valid_ff;
   logic signed [POINT_W-1:0] px_ff, py_ff;
   logic                      pw_ff;

   assign status.last     = last_ff;
   assign status.out_busy = rsp_valid_ff && rsp_stall;

   // time step register
   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= '0;
      end else if (csr_wr_en) begin
         time_step_ff <= csr_wr_data;
      end
   end

   // term capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         harm_ff  <= req_harmonic;
         amp_ff   <= req_amplitude;
         phase_ff <= req_phase_turns;
         last_ff  <= req_last_term;
      end
   end

   // angle = harmonic * time + phase mod one turn; start radius = amp * gain
   assign hprod  = harm_ff * $signed({1'b0, tp_ff});
   assign a16_in = hprod[PHASE_W-1:0] + phase_ff;
   assign gprod  = {{GAIN_W{1'b0}}, amp_ff} * {{AMP_W{1'b0}}, GAIN_Q30};

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         a16_ff <= a16_in;
         x0_ff  <= gprod[GPROD_W-1:GAIN_SHIFT];
      end
   end

   // quarter-turn reduction, then CORDIC micro-rotations
   assign turn  = {a16_ff, {(TURN_W - PHASE_W){1'b0}}} & ANGLE_MASK;
   assign z_raw = $signed({turn[TURN_W-1], turn});
   assign xs    = x_ff >>> cmd.step;
   assign ys    = y_ff >>> cmd.step;
   assign at    = $signed({1'b0, atan_turns(cmd.step)});

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         x_ff <= $signed({{(VEC_W - X0_W){1'b0}}, x0_ff});
         y_ff <= '0;
         if (z_raw > QUARTER_TURN) begin
            z_ff    <= z_raw - HALF_TURN;
            flip_ff <= 1'b1;
         end else if (z_raw < -QUARTER_TURN) begin
            z_ff    <= z_raw + HALF_TURN;
            flip_ff <= 1'b1;
         end else begin
            z_ff    <= z_raw;
            flip_ff <= 1'b0;
         end
      end else if (cmd.iter) begin
         if (z_ff >= 0) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + at;
         end
      end
   end

   // negate on flip (~v + 1) folded into the rounding add, then floor shift
   assign rx = (flip_ff ? ~x_ff : x_ff) + (flip_ff ? RND_BIAS + 1'b1 : RND_BIAS);
   assign ry = (flip_ff ? ~y_ff : y_ff) + (flip_ff ? RND_BIAS + 1'b1 : RND_BIAS);

   always_ff @(posedge clock) begin
      if (cmd.rnd) begin
         cx_ff <= rx[VEC_W-1:EXTRA_BITS];
         sy_ff <= ry[VEC_W-1:EXTRA_BITS];
      end
   end

   // saturating accumulation and time advance
   assign ax       = {{(ACC_W - POINT_W){sum_x_ff[POINT_W-1]}}, sum_x_ff}
                   + {{(ACC_W - CPT_W){cx_ff[CPT_W-1]}}, cx_ff};
   assign ay       = {{(ACC_W - POINT_W){sum_y_ff[POINT_W-1]}}, sum_y_ff}
                   + {{(ACC_W - CPT_W){sy_ff[CPT_W-1]}}, sy_ff};
   assign sum_x_in = sat_point(ax);
   assign sum_y_in = sat_point(ay);
   assign t_next   = {1'b0, tp_ff} + {1'b0, time_step_ff};
   assign wrap     = t_next > {1'b0, FULL_TURN};

   always_ff @(posedge clock) begin
      if (reset) begin
         tp_ff    <= '0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
      end else if (cmd.load && req_restart) begin
         tp_ff <= '0;
      end else if (cmd.acc) begin
         if (last_ff) begin
            sum_x_ff <= '0;
            sum_y_ff <= '0;
            tp_ff    <= wrap ? '0 : t_next[TIME_W-1:0];
         end else begin
            sum_x_ff <= sum_x_in;
            sum_y_ff <= sum_y_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.acc && last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc && last_ff) begin
         px_ff <= sum_x_in;
         py_ff <= sum_y_in;
         pw_ff <= wrap;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_point_x        = px_ff;
   assign rsp_point_y        = py_ff;
   assign rsp_period_wrapped = pw_ff;

`ifndef SYNTHESIS
   // a new point never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.acc && last_ff) |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   // a result appears only from the accumulation of a last term
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.acc && last_ff))
      else $error("result raised without a last term");

   // sums start fresh after each frame
   a_sums_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.acc && last_ff) |=> (sum_x_ff == '0) && (sum_y_ff == '0))
      else $error("sums not cleared after frame");

   // time never rests beyond one full turn
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      tp_ff <= FULL_TURN)
      else $error("time position beyond a full turn");
`endif

endmodule
